// ===== rtl/fla_pkg.sv =====
// Package for the free-list block allocator.
// Types, codes and default sizes shared by the cell, top-level, checker and testbench files.
// No dependencies.
package fla_pkg;

   localparam int DEF_REGION_MAX_BYTES = 65536;
   localparam int DEF_MAX_FREE_BLOCKS  = 64;
   localparam int DEF_GRANULE_BYTES    = 16;  // power of two

   localparam int OFFSET_W    = 16;
   localparam int REQ_W       = 16;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_POLICY   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BYTES = 1'b1;

   localparam logic OP_ALLOC  = 1'b0;
   localparam logic OP_FREE   = 1'b1;
   localparam logic FIT_FIRST = 1'b0;
   localparam logic FIT_BEST  = 1'b1;

   typedef struct packed {
      logic                opcode;
      logic [REQ_W-1:0]    request_bytes;
      logic [OFFSET_W-1:0] free_offset;
   } fla_req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] payload_offset;
      logic                granted;
   } fla_rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_TAKE_LEFT,
      CELL_TAKE_RIGHT
   } fla_cell_cmd_type;

   typedef struct packed {
      fla_cell_cmd_type cmd;
      logic             valid;
   } fla_cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_BEST,
      ST_ALLOC,
      ST_FCHK,
      ST_FACT,
      ST_FAIL
   } fla_state_type;

endpackage

// ===== rtl/free_list_block_allocator.sv =====
// Top level of the free-list block allocator: control sequencer, table cells, size store.
// Depends on fla_pkg, fla_cell and fla_ram.
//
// Usage:
//  req_*  : one word per request. opcode 0 allocates request_bytes (rounded up to a
//           granule), opcode 1 frees the block whose payload starts at free_offset.
//  rsp_*  : one word per request: payload_offset and granted. Fails give zero offset.
//  csr_*  : index 0 fit policy (0 first fit, 1 best fit), index 1 region size in bytes.
//           A region write reloads the free table with one block; taken only when idle.
// Steps, from acceptance to the response:
//  allocate, first fit : parallel cell compare, then grant + table update
//  allocate, best fit  : one cell examined per cycle, then grant + table update
//  free                : size store read, neighbor check, then merge/insert
//  free, bad offset    : rejected straight away, no size store read
// One request is in work at a time; a new request is taken in the cycle after its
// response is loaded, even while the previous response still waits in the output
// register.
// A shift of the table (insert or remove) moves every cell one place at once.
// Reset loads one free block covering the whole region and needs no clearing pass.
// The size store is not cleared. When rsp_ready stays low the finished
// request holds in its last step until the output register frees up.
module free_list_block_allocator #(
   parameter int REGION_MAX_BYTES = fla_pkg::DEF_REGION_MAX_BYTES,
   parameter int MAX_FREE_BLOCKS  = fla_pkg::DEF_MAX_FREE_BLOCKS,
   parameter int GRANULE_BYTES    = fla_pkg::DEF_GRANULE_BYTES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  fla_pkg::fla_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output fla_pkg::fla_rsp_type         rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [fla_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fla_pkg::CSR_DATA_W-1:0]  csr_data
);
   import fla_pkg::*;

   // internal arithmetic width: covers region, ends and merged lengths
   localparam int AW  = ($clog2(REGION_MAX_BYTES) + 2 > 18) ? $clog2(REGION_MAX_BYTES) + 2 : 18;
   localparam int GL  = $clog2(GRANULE_BYTES);
   localparam int STORE_DEPTH = REGION_MAX_BYTES / GRANULE_BYTES;
   localparam int AD  = $clog2(STORE_DEPTH);
   localparam int CW  = $clog2(MAX_FREE_BLOCKS);
   localparam int CNW = $clog2(MAX_FREE_BLOCKS + 1);
   localparam logic [AW-1:0] GRAN      = AW'(GRANULE_BYTES);
   localparam logic [AW-1:0] GRAN_MASK = AW'(GRANULE_BYTES - 1);
   localparam logic [AW-1:0] REG_MAX   = AW'(REGION_MAX_BYTES);
   localparam logic [AW-1:0] REG_MIN   = AW'(2 * GRANULE_BYTES);

   // sequencer and result registers
   fla_state_type   state_ff, state_in;
   logic [CNW-1:0]  count_ff, count_in;
   logic            policy_ff, policy_in;
   logic [AW-1:0]   region_ff, region_in;
   logic [AW-1:0]   need_ff, need_in;
   logic [AW-1:0]   node_ff, node_in;
   logic            idx_ok_ff, idx_ok_in;
   logic [CW-1:0]   pick_ff, pick_in;
   logic            found_ff, found_in;
   logic [AW-1:0]   pick_len_ff, pick_len_in;
   logic [CW-1:0]   scan_ff, scan_in;
   logic [AW-1:0]   size_ff, size_in;
   logic [CNW-1:0]  pos_ff, pos_in;
   logic [AW-1:0]   prev_start_ff, prev_start_in;
   logic [AW-1:0]   prev_len_ff, prev_len_in;
   logic [AW-1:0]   next_len_ff, next_len_in;
   logic            prev_adj_ff, prev_adj_in;
   logic            next_adj_ff, next_adj_in;
   logic            bad_ff, bad_in;
   logic            rsp_valid_ff, rsp_valid_in;
   fla_rsp_type     rsp_data_ff, rsp_data_in;

   // cell row
   fla_cell_ctl_type cell_ctl [MAX_FREE_BLOCKS];
   logic [AW-1:0]    cell_start [MAX_FREE_BLOCKS];
   logic [AW-1:0]    cell_len [MAX_FREE_BLOCKS];
   logic [MAX_FREE_BLOCKS-1:0] cell_fit;
   logic [MAX_FREE_BLOCKS-1:0] cell_above;
   logic [AW-1:0]    ld_start, ld_len;

   // size store
   logic            ram_we, ram_re;
   logic [AD-1:0]   ram_waddr, ram_raddr;
   logic [AW-1:0]   ram_wdata, ram_rdata;

   // helpers
   logic            can_out, emit;
   fla_rsp_type     emit_data;
   logic [CW-1:0]   first_fit;
   logic [CNW-1:0]  first_above;
   logic [AW-1:0]   sel_start, sel_len, spare, sidx, gsize;
   logic [AW-1:0]   off_ext, node_new, fsize, fend, p_start, p_len, p_end, n_start, n_len;
   logic [AW-1:0]   region_w;
   logic [CW-1:0]   pos_m1, pos_c;

   genvar g;
   generate
      for (g = 0; g < MAX_FREE_BLOCKS; g++) begin : g_cell
         logic [AW-1:0] l_start, l_len, r_start, r_len;
         if (g == 0) begin : g_first
            assign l_start = '0;
            assign l_len   = '0;
         end else begin : g_mid_l
            assign l_start = cell_start[g-1];
            assign l_len   = cell_len[g-1];
         end
         if (g == MAX_FREE_BLOCKS - 1) begin : g_last
            assign r_start = '0;
            assign r_len   = '0;
         end else begin : g_mid_r
            assign r_start = cell_start[g+1];
            assign r_len   = cell_len[g+1];
         end
         fla_cell #(.AW(AW)) u_cell (
            .clock       (clock),
            .ctl         (cell_ctl[g]),
            .need        (need_ff),
            .node        (node_ff),
            .load_start  (ld_start),
            .load_len    (ld_len),
            .left_start  (l_start),
            .left_len    (l_len),
            .right_start (r_start),
            .right_len   (r_len),
            .start_q     (cell_start[g]),
            .len_q       (cell_len[g]),
            .fit         (cell_fit[g]),
            .above       (cell_above[g])
         );
      end
   endgenerate

   fla_ram #(.WIDTH(AW), .DEPTH(STORE_DEPTH)) u_size_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // lowest-index fitting cell and lowest cell above the freed header
   always_comb begin
      first_fit   = '0;
      first_above = count_ff;
      for (int k = MAX_FREE_BLOCKS - 1; k >= 0; k--) begin
         if (cell_fit[k]) begin
            first_fit = CW'(k);
         end
         if (cell_above[k]) begin
            first_above = CNW'(k);
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign can_out   = !rsp_valid_ff || rsp_ready;
   assign pos_m1    = CW'(pos_ff - CNW'(1));
   assign pos_c     = pos_ff[CW-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      policy_in     = policy_ff;
      region_in     = region_ff;
      need_in       = need_ff;
      node_in       = node_ff;
      idx_ok_in     = idx_ok_ff;
      pick_in       = pick_ff;
      found_in      = found_ff;
      pick_len_in   = pick_len_ff;
      scan_in       = scan_ff;
      size_in       = size_ff;
      pos_in        = pos_ff;
      prev_start_in = prev_start_ff;
      prev_len_in   = prev_len_ff;
      next_len_in   = next_len_ff;
      prev_adj_in   = prev_adj_ff;
      next_adj_in   = next_adj_ff;
      bad_in        = bad_ff;
      ld_start      = '0;
      ld_len        = '0;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = '0;
      emit          = 1'b0;
      emit_data     = '0;
      sel_start     = cell_start[pick_ff];
      sel_len       = cell_len[pick_ff];
      spare         = sel_len - need_ff;
      sidx          = sel_start >> GL;
      gsize         = need_ff;
      off_ext       = AW'(req_data.free_offset);
      node_new      = off_ext - GRAN;
      fsize         = idx_ok_ff ? ram_rdata : '0;
      fend          = node_ff + GRAN + fsize;
      p_start       = cell_start[CW'(first_above - CNW'(1))];
      p_len         = cell_len[CW'(first_above - CNW'(1))];
      p_end         = p_start + GRAN + p_len;
      n_start       = cell_start[first_above[CW-1:0]];
      n_len         = cell_len[first_above[CW-1:0]];
      region_w      = AW'(csr_data);
      for (int k = 0; k < MAX_FREE_BLOCKS; k++) begin
         cell_ctl[k].cmd   = CELL_HOLD;
         cell_ctl[k].valid = (CNW'(k) < count_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.opcode == OP_ALLOC) begin
                  need_in  = (AW'(req_data.request_bytes) + GRAN_MASK) & ~GRAN_MASK;
                  found_in = 1'b0;
                  scan_in  = '0;
                  state_in = ST_SCAN;
               end else if ((off_ext < GRAN) || ((off_ext & GRAN_MASK) != '0)) begin
                  state_in = ST_FAIL;
               end else begin
                  node_in   = node_new;
                  idx_ok_in = ((node_new >> GL) < AW'(STORE_DEPTH));
                  ram_re    = 1'b1;
                  ram_raddr = AD'(node_new >> GL);
                  state_in  = ST_FCHK;
               end
            end
         end
         ST_SCAN: begin
            if (policy_ff == FIT_FIRST) begin
               found_in = |cell_fit;
               pick_in  = first_fit;
               state_in = ST_ALLOC;
            end else if (count_ff == '0) begin
               state_in = ST_ALLOC;
            end else begin
               state_in = ST_BEST;
            end
         end
         ST_BEST: begin
            // one cell per cycle; strict less keeps the first of the smallest
            if (cell_fit[scan_ff] && (!found_ff || (cell_len[scan_ff] < pick_len_ff))) begin
               found_in    = 1'b1;
               pick_in     = scan_ff;
               pick_len_in = cell_len[scan_ff];
            end
            if ((CNW'(scan_ff) + CNW'(1)) == count_ff) begin
               state_in = ST_ALLOC;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         ST_ALLOC: begin
            if (can_out) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (found_ff) begin
                  if (spare >= GRAN + AW'(1)) begin
                     // split: the tail stays free
                     cell_ctl[pick_ff].cmd = CELL_LOAD;
                     ld_start = sel_start + GRAN + need_ff;
                     ld_len   = spare - GRAN;
                     gsize    = need_ff;
                  end else begin
                     for (int k = 0; k < MAX_FREE_BLOCKS; k++) begin
                        if (CW'(k) >= pick_ff) begin
                           cell_ctl[k].cmd = CELL_TAKE_RIGHT;
                        end
                     end
                     count_in = count_ff - CNW'(1);
                     gsize    = sel_len;
                  end
                  if (sidx < AW'(STORE_DEPTH)) begin
                     ram_we    = 1'b1;
                     ram_waddr = AD'(sidx);
                     ram_wdata = gsize;
                  end
                  emit_data.payload_offset = OFFSET_W'(sel_start + GRAN);
                  emit_data.granted        = 1'b1;
               end
            end
         end
         ST_FCHK: begin
            size_in       = fsize;
            pos_in        = first_above;
            prev_start_in = p_start;
            prev_len_in   = p_len;
            next_len_in   = n_len;
            prev_adj_in   = (first_above != '0) && (p_end == node_ff);
            next_adj_in   = (first_above < count_ff) && (fend == n_start);
            bad_in        = (fend > region_ff)
                            || ((first_above != '0) && (p_end > node_ff))
                            || ((first_above < count_ff) && (fend > n_start));
            state_in      = ST_FACT;
         end
         ST_FACT: begin
            if (can_out) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (!bad_ff) begin
                  emit_data.granted = 1'b1;
                  if (prev_adj_ff && next_adj_ff) begin
                     cell_ctl[pos_m1].cmd = CELL_LOAD;
                     ld_start = prev_start_ff;
                     ld_len   = prev_len_ff + GRAN + size_ff + GRAN + next_len_ff;
                     for (int k = 0; k < MAX_FREE_BLOCKS; k++) begin
                        if (CNW'(k) >= pos_ff) begin
                           cell_ctl[k].cmd = CELL_TAKE_RIGHT;
                        end
                     end
                     count_in = count_ff - CNW'(1);
                  end else if (prev_adj_ff) begin
                     cell_ctl[pos_m1].cmd = CELL_LOAD;
                     ld_start = prev_start_ff;
                     ld_len   = prev_len_ff + GRAN + size_ff;
                  end else if (next_adj_ff) begin
                     cell_ctl[pos_c].cmd = CELL_LOAD;
                     ld_start = node_ff;
                     ld_len   = size_ff + GRAN + next_len_ff;
                  end else if (count_ff >= CNW'(MAX_FREE_BLOCKS)) begin
                     // table full, no neighbor to merge with
                     emit_data.granted = 1'b0;
                  end else begin
                     for (int k = 0; k < MAX_FREE_BLOCKS; k++) begin
                        if (CNW'(k) > pos_ff) begin
                           cell_ctl[k].cmd = CELL_TAKE_LEFT;
                        end
                     end
                     cell_ctl[pos_c].cmd = CELL_LOAD;
                     ld_start = node_ff;
                     ld_len   = size_ff;
                     count_in = count_ff + CNW'(1);
                  end
               end
            end
         end
         ST_FAIL: begin
            if (can_out) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes, idle only
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FIT_POLICY) begin
            policy_in = csr_data[0];
         end else if (csr_index == CSR_REGION_BYTES) begin
            if (region_w < REG_MIN) begin
               region_w = REG_MIN;
            end
            if (region_w > REG_MAX) begin
               region_w = REG_MAX;
            end
            region_w        = region_w & ~GRAN_MASK;
            region_in       = region_w;
            count_in        = CNW'(1);
            cell_ctl[0].cmd = CELL_LOAD;
            ld_start        = '0;
            ld_len          = region_w - GRAN;
         end
      end

      // reset seeds the single free block
      if (reset) begin
         cell_ctl[0].cmd = CELL_LOAD;
         ld_start        = '0;
         ld_len          = REG_MAX - GRAN;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNW'(1);
         policy_ff    <= FIT_FIRST;
         region_ff    <= REG_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         policy_ff    <= policy_in;
         region_ff    <= region_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff       <= need_in;
      node_ff       <= node_in;
      idx_ok_ff     <= idx_ok_in;
      pick_ff       <= pick_in;
      found_ff      <= found_in;
      pick_len_ff   <= pick_len_in;
      scan_ff       <= scan_in;
      size_ff       <= size_in;
      pos_ff        <= pos_in;
      prev_start_ff <= prev_start_in;
      prev_len_ff   <= prev_len_in;
      next_len_ff   <= next_len_in;
      prev_adj_ff   <= prev_adj_in;
      next_adj_ff   <= next_adj_in;
      bad_ff        <= bad_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ===== rtl/fla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fla_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/fla_cell.sv =====
// One free-table entry: header offset and payload length, with neighbor shift.
// Depends on fla_pkg.
module fla_cell #(
   parameter int AW = 18
) (
   input  logic                     clock,
   input  fla_pkg::fla_cell_ctl_type ctl,
   input  logic [AW-1:0]            need,
   input  logic [AW-1:0]            node,
   input  logic [AW-1:0]            load_start,
   input  logic [AW-1:0]            load_len,
   input  logic [AW-1:0]            left_start,
   input  logic [AW-1:0]            left_len,
   input  logic [AW-1:0]            right_start,
   input  logic [AW-1:0]            right_len,
   output logic [AW-1:0]            start_q,
   output logic [AW-1:0]            len_q,
   output logic                     fit,
   output logic                     above
);
   import fla_pkg::*;

   logic [AW-1:0] start_ff, start_in;
   logic [AW-1:0] len_ff, len_in;

   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      case (ctl.cmd)
         CELL_HOLD: begin
         end
         CELL_LOAD: begin
            start_in = load_start;
            len_in   = load_len;
         end
         CELL_TAKE_LEFT: begin
            start_in = left_start;
            len_in   = left_len;
         end
         CELL_TAKE_RIGHT: begin
            start_in = right_start;
            len_in   = right_len;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
   end

   assign start_q = start_ff;
   assign len_q   = len_ff;
   assign fit     = ctl.valid && (len_ff >= need);
   assign above   = ctl.valid && (start_ff > node);
endmodule

// ===== sim/fla_checker.sv =====
// Response checker for the free-list block allocator: watches the three channels,
// keeps its own copy of the free table and size store, and compares every response word.
// Depends on fla_pkg.
module fla_checker #(
   parameter int REGION_MAX_BYTES = fla_pkg::DEF_REGION_MAX_BYTES,
   parameter int MAX_FREE_BLOCKS  = fla_pkg::DEF_MAX_FREE_BLOCKS,
   parameter int GRANULE_BYTES    = fla_pkg::DEF_GRANULE_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  fla_pkg::fla_req_type              req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  fla_pkg::fla_rsp_type              rsp_data,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [fla_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fla_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fla_pkg::*;

   localparam int unsigned GRAN        = GRANULE_BYTES;
   localparam int unsigned STORE_DEPTH = REGION_MAX_BYTES / GRANULE_BYTES;

   logic                 fit_sel;
   int unsigned          region_size;
   int unsigned          blk_base [MAX_FREE_BLOCKS];
   int unsigned          blk_len  [MAX_FREE_BLOCKS];
   int unsigned          blk_cnt;
   int unsigned          size_store [STORE_DEPTH];
   fla_rsp_type          expected_rsp_q [$];

   task automatic reload_table();
      blk_cnt     = 1;
      blk_base[0] = 0;
      blk_len[0]  = region_size - GRAN;
   endtask

   task automatic drop_entry(input int unsigned i);
      for (int unsigned k = i; k + 1 < blk_cnt; k++) begin
         blk_base[k] = blk_base[k+1];
         blk_len[k]  = blk_len[k+1];
      end
      blk_cnt--;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      int unsigned r;
      if (idx == CSR_FIT_POLICY) begin
         fit_sel = d[0];
      end else begin
         r = 32'(d);
         if (r < 2 * GRAN) r = 2 * GRAN;
         if (r > REGION_MAX_BYTES) r = REGION_MAX_BYTES;
         region_size = (r / GRAN) * GRAN;
         reload_table();
      end
   endtask

   task automatic predict_alloc(input int unsigned nbytes, output fla_rsp_type r);
      int unsigned need, pick, base, len, gsz;
      bit          found;
      need  = ((nbytes + GRAN - 1) / GRAN) * GRAN;
      pick  = 0;
      found = 0;
      r     = '0;
      for (int unsigned i = 0; i < blk_cnt; i++) begin
         if (blk_len[i] >= need) begin
            if (!found || (fit_sel == FIT_BEST && blk_len[i] < blk_len[pick])) begin
               pick  = i;
               found = 1;
               if (fit_sel == FIT_FIRST) break;
            end
         end
      end
      if (!found) return;
      base = blk_base[pick];
      len  = blk_len[pick];
      if (len - need >= GRAN + 1) begin
         blk_base[pick] = base + GRAN + need;
         blk_len[pick]  = len - GRAN - need;
         gsz = need;
      end else begin
         drop_entry(pick);
         gsz = len;
      end
      if (base / GRAN < STORE_DEPTH) size_store[base / GRAN] = gsz;
      r.payload_offset = 16'((base + GRAN) & 16'hFFFF);
      r.granted        = 1'b1;
   endtask

   task automatic predict_free(input int unsigned off, output fla_rsp_type r);
      int unsigned node, idx, sz, node_end, i;
      bit          prev_adj, next_adj;
      r = '0;
      if (off < GRAN || off % GRAN != 0) return;
      node     = off - GRAN;
      idx      = node / GRAN;
      sz       = (idx < STORE_DEPTH) ? size_store[idx] : 0;
      node_end = node + GRAN + sz;
      if (node_end > region_size) return;
      for (i = 0; i < blk_cnt; i++)
         if (blk_base[i] > node) break;
      // overlap with either neighbor (double free and the like)
      if (i > 0 && blk_base[i-1] + GRAN + blk_len[i-1] > node) return;
      if (i < blk_cnt && node_end > blk_base[i]) return;
      prev_adj = i > 0 && blk_base[i-1] + GRAN + blk_len[i-1] == node;
      next_adj = i < blk_cnt && node_end == blk_base[i];
      if (prev_adj && next_adj) begin
         blk_len[i-1] += GRAN + sz + GRAN + blk_len[i];
         drop_entry(i);
      end else if (prev_adj) begin
         blk_len[i-1] += GRAN + sz;
      end else if (next_adj) begin
         blk_len[i]  = sz + GRAN + blk_len[i];
         blk_base[i] = node;
      end else begin
         if (blk_cnt >= MAX_FREE_BLOCKS) return;
         for (int unsigned k = blk_cnt; k > i; k--) begin
            blk_base[k] = blk_base[k-1];
            blk_len[k]  = blk_len[k-1];
         end
         blk_base[i] = node;
         blk_len[i]  = sz;
         blk_cnt++;
      end
      r.granted = 1'b1;
   endtask

   always @(posedge clock) begin
      fla_rsp_type exp_word;
      fla_rsp_type pred;
      if (reset) begin
         fit_sel     = FIT_FIRST;
         region_size = REGION_MAX_BYTES;
         reload_table();
         expected_rsp_q.delete();
         fail_count  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (expected_rsp_q.size() != 0) begin
               if (fail_count < 10) $display("%0t: register write while busy", $realtime);
               fail_count++;
            end
            write_csr(csr_index, csr_data);
         end
         // responses first: a word leaving now belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected response word %h", $realtime, rsp_data);
               fail_count++;
            end else begin
               exp_word = expected_rsp_q.pop_front();
               if (rsp_data.payload_offset !== exp_word.payload_offset ||
                   rsp_data.granted !== exp_word.granted) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch offset exp %h got %h, granted exp %b got %b",
                              $realtime, exp_word.payload_offset, rsp_data.payload_offset,
                              exp_word.granted, rsp_data.granted);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.opcode == OP_ALLOC) predict_alloc(32'(req_data.request_bytes), pred);
            else                             predict_free(32'(req_data.free_offset), pred);
            expected_rsp_q.push_back(pred);
         end
      end
   end

   // expectations still queued at the end of the run
   function automatic int leftover();
      return expected_rsp_q.size();
   endfunction

endmodule

// ===== sim/free_list_block_allocator_tb.sv =====
// Testbench top for the free-list block allocator: clock, reset, stimulus and verdict.
// Depends on fla_pkg, fla_checker and the allocator RTL.
module free_list_block_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fla_pkg::*;

   localparam int GRAN = DEF_GRANULE_BYTES;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   fla_req_type             req_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   fla_rsp_type             rsp_data;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;
   int                      fail_count;

   // stimulus bookkeeping
   int          words_sent;
   int          words_back;
   logic        sent_op_q [$];      // opcode of every accepted request, in order
   int unsigned live_q [$];         // payload offsets currently held by the stimulus
   int unsigned touched_q [$];      // every offset ever granted (size entry written)
   bit          touched [int unsigned];
   int unsigned cur_region;
   bit          gaps_on;
   bit          stall_on;

   free_list_block_allocator dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   fla_checker chk (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #8ms;
      $display("Simulation FAILED");
      $finish;
   end

   // track granted offsets so frees only ever name blocks whose size entry was written
   always @(posedge clock) begin
      logic        op;
      int unsigned got;
      if (!reset && rsp_valid && rsp_ready && sent_op_q.size() != 0) begin
         op = sent_op_q.pop_front();
         words_back++;
         if (op == OP_ALLOC && rsp_data.granted) begin
            got = 32'(rsp_data.payload_offset);
            live_q.push_back(got);
            if (!touched.exists(got)) begin
               touched[got] = 1;
               touched_q.push_back(got);
            end
         end
      end
   end

   // receiver: mostly ready, short stalls, now and then a long one
   initial begin
      int stall_left;
      int roll;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (!stall_on) begin
            rsp_ready = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               rsp_ready = 1'b1;
            end else if (roll < 95) begin
               stall_left = $urandom_range(0, 2);
               rsp_ready  = 1'b0;
            end else begin
               stall_left = $urandom_range(10, 40);
               rsp_ready  = 1'b0;
            end
         end
      end
   end

   task automatic idle_gap();
      int r;
      if (!gaps_on) return;
      r = $urandom_range(0, 99);
      if (r < 60) return;
      repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clock);
   endtask

   // one request word; valid is held until accepted
   task automatic send_word(input logic op, input int unsigned nbytes, input int unsigned off);
      idle_gap();
      req_valid              = 1'b1;
      req_data.opcode        = op;
      req_data.request_bytes = nbytes[15:0];
      req_data.free_offset   = off[15:0];
      do @(posedge clock); while (!req_ready);
      sent_op_q.push_back(op);
      words_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (words_back != words_sent) @(negedge clock);
      // best fit walks the whole table; let the sequencer settle
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      int unsigned r;
      wait_drained();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      if (idx == CSR_REGION_BYTES) begin
         r = value & 32'h1FFFF;
         if (r < 2 * GRAN) r = 2 * GRAN;
         if (r > DEF_REGION_MAX_BYTES) r = DEF_REGION_MAX_BYTES;
         cur_region = (r / GRAN) * GRAN;
         live_q.delete();   // every block is free again
      end
   endtask

   task automatic free_live(input int unsigned pos);
      int unsigned off;
      off = live_q[pos];
      live_q.delete(pos);
      send_word(OP_FREE, $urandom() & 16'hFFFF, off);
   endtask

   // misaligned, below one granule, or a stale/duplicate offset
   task automatic free_noise();
      int unsigned off;
      case ($urandom_range(0, 2))
         0: off = ($urandom() & 16'hFFF0) | $urandom_range(1, GRAN - 1);
         1: off = $urandom_range(0, GRAN - 1);
         default:
            off = touched_q.size() ? touched_q[$urandom_range(0, touched_q.size() - 1)]
                                   : $urandom_range(1, GRAN - 1);
      endcase
      send_word(OP_FREE, $urandom() & 16'hFFFF, off);
   endtask

   task automatic random_word();
      int          p;
      int unsigned nbytes;
      p = $urandom_range(0, 99);
      if (p < 50 || live_q.size() == 0 && p < 88) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: nbytes = $urandom_range(0, cur_region / 8);
            7, 8:                nbytes = $urandom_range(0, cur_region);
            default:             nbytes = $urandom() & 16'hFFFF;
         endcase
         if (nbytes > 16'hFFFF) nbytes = 16'hFFFF;
         send_word(OP_ALLOC, nbytes, $urandom() & 16'hFFFF);
      end else if (p < 88) begin
         free_live($urandom_range(0, live_q.size() - 1));
      end else begin
         free_noise();
      end
   endtask

   initial begin
      int unsigned fit_list    [8] = '{0, 1, 0, 1, 0, 1, 0, 1};
      int unsigned region_list [8] = '{65536, 20, 131071, 1000, 0, 65536, 300, 4096};
      int          n;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_FIT_POLICY;
      csr_data   = '0;
      words_sent = 0;
      words_back = 0;
      cur_region = DEF_REGION_MAX_BYTES;
      gaps_on    = 1'b0;
      stall_on   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, first fit over the full region
      send_word(OP_ALLOC, 0, 0);                   // zero-byte block
      send_word(OP_ALLOC, 1, 16'hFFFF);            // rounds up to one granule
      send_word(OP_ALLOC, 16'hFFFF, 0);            // no fitting block
      send_word(OP_ALLOC, 100, 0);
      send_word(OP_FREE, 0, 0);                    // below one granule
      send_word(OP_FREE, 0, 16'h0021);             // off the granule grid
      wait_drained();
      free_live(1);                                // middle block, no neighbor
      send_word(OP_FREE, 0, touched_q[1]);         // double free
      free_live(0);                                // merges with the right neighbor
      free_live(0);                                // merges on both sides
      send_word(OP_ALLOC, 65504, 0);               // leaves only a granule spare, granted whole
      send_word(OP_ALLOC, 65520 - 16, 0);
      send_word(OP_ALLOC, 0, 0);
      wait_drained();
      while (live_q.size()) free_live(0);          // into the empty list as its only block

      // full table: many zero-byte blocks, then free every other one
      send_word(OP_ALLOC, 0, 0);
      repeat (139) send_word(OP_ALLOC, 0, 0);
      wait_drained();
      n = 0;
      while (n < live_q.size()) begin
         free_live(n);
         n++;
      end
      wait_drained();
      write_reg(CSR_REGION_BYTES, 65536);

      // random phases over a range of settings, extremes included
      gaps_on  = 1'b1;
      stall_on = 1'b1;
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_FIT_POLICY, fit_list[ph]);
         write_reg(CSR_REGION_BYTES, region_list[ph]);
         gaps_on  = (ph % 3) != 2;
         stall_on = (ph % 4) != 3;
         repeat (140) random_word();
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && chk.leftover() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
